// ===== hdl/hdc_pkg.sv =====
`default_nettype none

package hdc_pkg;

    localparam int TEMP_W = 16;
    localparam int PRESS_W = 12;
    localparam int DUTY_W = 7;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic signed [16:0] DEADBAND = 17'sd32;
    localparam logic [DUTY_W-1:0] LEVEL_FULL = 7'd100;

    localparam logic signed [TEMP_W-1:0] PHASE_ONE_RST = 16'sd1280;
    localparam logic signed [TEMP_W-1:0] PHASE_TWO_RST = 16'sd1920;
    localparam logic [PRESS_W-1:0] PRESS_CRIT_RST = 12'd500;
    localparam logic [PRESS_W-1:0] PRESS_WARN_RST = 12'd460;
    localparam logic [15:0] RISE_LIMIT_RST = 16'd128;
    localparam logic [DUTY_W-1:0] RAMP_LIMIT_RST = 7'd10;
    localparam logic [DUTY_W-1:0] DUTY_MAX_RST = 7'd100;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PHASE_ONE  = 3'd0,
        CFG_PHASE_TWO  = 3'd1,
        CFG_PRESS_CRIT = 3'd2,
        CFG_PRESS_WARN = 3'd3,
        CFG_RISE_LIMIT = 3'd4,
        CFG_RAMP_LIMIT = 3'd5,
        CFG_DUTY_MAX   = 3'd6
    } t_cfg_index;

    typedef enum logic [1:0] {
        REASON_NORMAL   = 2'd0,
        REASON_DERATE   = 2'd1,
        REASON_CRITICAL = 2'd2,
        REASON_DISABLED = 2'd3
    } t_reason;

    typedef struct packed {
        logic signed [TEMP_W-1:0] phase_one_target;
        logic signed [TEMP_W-1:0] phase_two_target;
        logic [PRESS_W-1:0]       pressure_critical;
        logic [PRESS_W-1:0]       pressure_warning;
        logic [15:0]              rise_limit;
        logic [DUTY_W-1:0]        ramp_limit;
        logic [DUTY_W-1:0]        duty_max;
    } t_cfg;

    typedef struct packed {
        logic [DUTY_W-1:0] heater_duty;
        logic [DUTY_W-1:0] cooler_level;
        t_reason           reason;
    } t_result;

endpackage

`default_nettype wire

// ===== hdl/hdc_core.sv =====
`default_nettype none

module hdc_core
    import hdc_pkg::*;
(
    input  wire t_cfg                      i_cfg,
    input  wire logic signed [TEMP_W-1:0]  i_temperature,
    input  wire logic [PRESS_W-1:0]        i_pressure,
    input  wire logic                      i_phase_two,
    input  wire logic                      i_enabled,
    input  wire logic signed [TEMP_W-1:0]  i_prev_temperature,
    input  wire logic [DUTY_W-1:0]         i_prev_duty,
    output t_result                        o_result
);

    logic signed [TEMP_W-1:0] target;
    logic signed [16:0]       err;
    logic signed [18:0]       err_x;
    logic signed [18:0]       err3;
    logic signed [17:0]       neg;
    logic signed [17:0]       rise;
    logic signed [15:0]       prev;
    logic signed [15:0]       duty;
    logic signed [15:0]       diff_up;
    logic signed [15:0]       diff_dn;
    logic signed [15:0]       ramp;
    logic signed [15:0]       top;
    logic [14:0]              cool_raw;
    logic                     critical;

    always_comb begin
        target   = i_phase_two ? i_cfg.phase_two_target : i_cfg.phase_one_target;
        err      = {target[TEMP_W-1], target} - {i_temperature[TEMP_W-1], i_temperature};
        err_x    = {{2{err[16]}}, err};
        err3     = err_x + {err_x[17:0], 1'b0};
        neg      = -{err[16], err};
        cool_raw = neg[16:2];
        rise     = {{2{i_temperature[TEMP_W-1]}}, i_temperature}
                 - {{2{i_prev_temperature[TEMP_W-1]}}, i_prev_temperature};
        critical = (i_pressure >= i_cfg.pressure_critical) ||
                   ((i_pressure >= i_cfg.pressure_warning) &&
                    (rise >= $signed({2'b00, i_cfg.rise_limit})));

        prev = $signed({9'd0, i_prev_duty});
        ramp = $signed({9'd0, i_cfg.ramp_limit});
        top  = (i_cfg.duty_max > LEVEL_FULL) ? $signed({9'd0, LEVEL_FULL})
                                             : $signed({9'd0, i_cfg.duty_max});

        o_result.cooler_level = '0;
        o_result.reason       = REASON_NORMAL;
        duty                  = prev;

        if (critical) begin
            duty                  = '0;
            o_result.cooler_level = LEVEL_FULL;
            o_result.reason       = REASON_CRITICAL;
        end else begin
            if (i_enabled) begin
                if (err > DEADBAND) begin
                    duty = prev + $signed({3'd0, err3[17:5]});
                end else if (err < -DEADBAND) begin
                    duty = prev - $signed({2'd0, neg[16:3]});
                    o_result.cooler_level = (cool_raw > 15'(LEVEL_FULL)) ? LEVEL_FULL
                                                                         : cool_raw[6:0];
                end
                if (i_pressure > i_cfg.pressure_warning) begin
                    // halve, truncating toward zero
                    duty = (duty + $signed({15'd0, duty[15]})) >>> 1;
                    o_result.reason = REASON_DERATE;
                end
            end else begin
                duty            = '0;
                o_result.reason = REASON_DISABLED;
            end

            diff_up = duty - prev;
            diff_dn = prev - duty;
            if (diff_up > ramp) begin
                duty = prev + ramp;
            end else if (diff_dn > ramp) begin
                duty = prev - ramp;
            end
            if (duty > top) begin
                duty = top;
            end
            if (duty < 0) begin
                duty = '0;
            end
        end

        diff_up = duty - prev;
        diff_dn = prev - duty;
        o_result.heater_duty = duty[DUTY_W-1:0];
    end

endmodule

`default_nettype wire

// ===== hdl/heater_duty_controller_unit.sv =====
// Heater duty controller: one heater/cooler update per control tick.
//
// Input channel: i_in_valid / o_in_stall carry one tick beat (temperature in
// 1/16 degree, pressure, phase select, enable). Output channel: o_out_valid /
// i_out_stall carry one result beat (heater duty, cooler level, reason).
// A beat moves at a clock edge where valid is high and stall is low.
//
// Pipeline: a tick moves from the input register to the result register.
// Throughput: one tick per cycle while the receiver does not stall; the
// limit is the update of previous duty and temperature, which each tick
// reads and writes in the same cycle, as it moves into the result register.
//
// Configuration: i_cfg_we writes i_cfg_wdata to register i_cfg_index
// (0 phase one target .. 6 duty max); unused indexes are dropped. Write only
// while the block is idle.
//
// Reset (i_rst_n low, synchronous) restores register defaults, clears the
// previous duty and temperature, and empties both stages. When the receiver
// stalls, the result is held and one more tick may wait in the input
// register; after that o_in_stall rises.
`default_nettype none

module heater_duty_controller_unit
    import hdc_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]    i_cfg_wdata,
    input  wire logic                     i_in_valid,
    output logic                          o_in_stall,
    input  wire logic signed [TEMP_W-1:0] i_temperature,
    input  wire logic [PRESS_W-1:0]       i_pressure,
    input  wire logic                     i_phase_two,
    input  wire logic                     i_enabled,
    output logic                          o_out_valid,
    input  wire logic                     i_out_stall,
    output logic [DUTY_W-1:0]             o_heater_duty,
    output logic [DUTY_W-1:0]             o_cooler_level,
    output logic [1:0]                    o_reason
);

    t_cfg                     r_cfg;
    logic                     r_in_vld;
    logic signed [TEMP_W-1:0] r_temperature;
    logic [PRESS_W-1:0]       r_pressure;
    logic                     r_phase_two;
    logic                     r_enabled;
    logic                     r_out_vld;
    t_result                  r_result;
    logic signed [TEMP_W-1:0] r_prev_temperature;
    logic [DUTY_W-1:0]        r_prev_duty;
    t_result                  n_result;
    logic                     advance;
    logic                     in_take;

    assign advance    = r_in_vld && (!r_out_vld || !i_out_stall);
    assign o_in_stall = r_in_vld && !advance;
    assign in_take    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.phase_one_target  <= PHASE_ONE_RST;
            r_cfg.phase_two_target  <= PHASE_TWO_RST;
            r_cfg.pressure_critical <= PRESS_CRIT_RST;
            r_cfg.pressure_warning  <= PRESS_WARN_RST;
            r_cfg.rise_limit        <= RISE_LIMIT_RST;
            r_cfg.ramp_limit        <= RAMP_LIMIT_RST;
            r_cfg.duty_max          <= DUTY_MAX_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_PHASE_ONE:  r_cfg.phase_one_target  <= $signed(i_cfg_wdata);
                CFG_PHASE_TWO:  r_cfg.phase_two_target  <= $signed(i_cfg_wdata);
                CFG_PRESS_CRIT: r_cfg.pressure_critical <= i_cfg_wdata[PRESS_W-1:0];
                CFG_PRESS_WARN: r_cfg.pressure_warning  <= i_cfg_wdata[PRESS_W-1:0];
                CFG_RISE_LIMIT: r_cfg.rise_limit        <= i_cfg_wdata;
                CFG_RAMP_LIMIT: r_cfg.ramp_limit        <= i_cfg_wdata[DUTY_W-1:0];
                CFG_DUTY_MAX:   r_cfg.duty_max          <= i_cfg_wdata[DUTY_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld           <= 1'b0;
            r_out_vld          <= 1'b0;
            r_prev_temperature <= '0;
            r_prev_duty        <= '0;
        end else begin
            if (in_take) begin
                r_in_vld <= 1'b1;
            end else if (advance) begin
                r_in_vld <= 1'b0;
            end
            if (advance) begin
                r_out_vld          <= 1'b1;
                r_prev_temperature <= r_temperature;
                r_prev_duty        <= n_result.heater_duty;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_temperature <= i_temperature;
            r_pressure    <= i_pressure;
            r_phase_two   <= i_phase_two;
            r_enabled     <= i_enabled;
        end
        if (advance) begin
            r_result <= n_result;
        end
    end

    hdc_core u_core (
        .i_cfg              (r_cfg),
        .i_temperature      (r_temperature),
        .i_pressure         (r_pressure),
        .i_phase_two        (r_phase_two),
        .i_enabled          (r_enabled),
        .i_prev_temperature (r_prev_temperature),
        .i_prev_duty        (r_prev_duty),
        .o_result           (n_result)
    );

    assign o_out_valid    = r_out_vld;
    assign o_heater_duty  = r_result.heater_duty;
    assign o_cooler_level = r_result.cooler_level;
    assign o_reason       = r_result.reason;

endmodule

`default_nettype wire
